@@ hw/rtl/mfs_pkg.sv @@
// Model format sniffer package: state and result types, phase and result codes,
// match tables and the per-byte text step functions.
// No dependencies.
`default_nettype none

package mfs_pkg;

  localparam int LENGTH_BITS = 32;
  typedef logic [LENGTH_BITS-1:0] count_t;

  // lead-in phase
  localparam logic [1:0] LP_WAIT  = 2'd0;
  localparam logic [1:0] LP_SKIP  = 2'd1;
  localparam logic [1:0] LP_FOUND = 2'd2;

  // line phase of the OBJ scanner
  localparam logic [2:0] LN_BETWEEN = 3'd0;
  localparam logic [2:0] LN_BLANKS  = 3'd1;
  localparam logic [2:0] LN_WORD    = 3'd2;
  localparam logic [2:0] LN_REST    = 3'd3;
  localparam logic [2:0] LN_STOP    = 3'd4;

  localparam logic [2:0] SOLID_FAIL = 3'd7;

  localparam logic [2:0] FMT_GLB  = 3'd0;
  localparam logic [2:0] FMT_GLTF = 3'd1;
  localparam logic [2:0] FMT_STL  = 3'd2;
  localparam logic [2:0] FMT_OBJ  = 3'd3;
  localparam logic [2:0] FMT_3MF  = 3'd4;

  localparam logic [2:0] RSN_UNKNOWN   = 3'd0;
  localparam logic [2:0] RSN_GLTF      = 3'd1;
  localparam logic [2:0] RSN_ZIP       = 3'd2;
  localparam logic [2:0] RSN_JSON      = 3'd3;
  localparam logic [2:0] RSN_ASCII_STL = 3'd4;
  localparam logic [2:0] RSN_STL_EXACT = 3'd5;
  localparam logic [2:0] RSN_STL_STRD  = 3'd6;
  localparam logic [2:0] RSN_OBJ       = 3'd7;

  localparam logic [7:0] SOLID_TOK [5] = '{8'h73, 8'h6F, 8'h6C, 8'h69, 8'h64};
  localparam logic [7:0] FACET_TOK [12] = '{8'h66, 8'h61, 8'h63, 8'h65, 8'h74, 8'h20,
                                            8'h6E, 8'h6F, 8'h72, 8'h6D, 8'h61, 8'h6C};
  localparam logic [7:0] ENDS_TOK [8] = '{8'h65, 8'h6E, 8'h64, 8'h73,
                                          8'h6F, 8'h6C, 8'h69, 8'h64};

  typedef struct packed {
    logic [1:0]  lead;
    logic [7:0]  fmc;
    logic [2:0]  solid;
    logic [3:0]  facet;
    logic [3:0]  endsolid;
    logic        stl_hit;
    logic [2:0]  line_phase;
    logic [47:0] line_word;
    logic [2:0]  word_len;
    logic [7:0]  lines_seen;
    logic        obj_hit;
  } txt_t;

  typedef struct packed {
    logic [2:0] format;
    logic [2:0] reason;
  } result_t;

  function automatic logic is_ws(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic [3:0] facet_step(logic [3:0] p, logic [7:0] c);
    if (p >= 4'd12) return 4'd12;
    if (c == FACET_TOK[p]) return p + 4'd1;
    return (c == FACET_TOK[0]) ? 4'd1 : 4'd0;
  endfunction

  function automatic logic [3:0] ends_step(logic [3:0] p, logic [7:0] c);
    if (p >= 4'd8) return 4'd8;
    if (c == ENDS_TOK[p[2:0]]) return p + 4'd1;
    return (c == ENDS_TOK[0]) ? 4'd1 : 4'd0;
  endfunction

  function automatic logic token_hit(logic [47:0] w, logic [2:0] n);
    logic one, two, six;
    one = w == 48'h76 || w == 48'h66 || w == 48'h6C || w == 48'h6F ||
          w == 48'h67 || w == 48'h73;
    two = w == 48'h766E || w == 48'h7674 || w == 48'h7670;
    six = w == 48'h6D746C6C6962 || w == 48'h7573656D746C;
    return (n == 3'd1 && one) || (n == 3'd2 && two) || (n == 3'd6 && six);
  endfunction

  function automatic txt_t line_failed(txt_t s);
    txt_t r;
    r = s;
    if (r.lines_seen != 8'hFF) r.lines_seen = r.lines_seen + 8'd1;
    r.line_phase = LN_REST;
    return r;
  endfunction

  function automatic txt_t judge_word(txt_t s);
    txt_t r;
    r = s;
    if (token_hit(r.line_word, r.word_len)) begin
      r.obj_hit = 1'b1;
      r.line_phase = LN_STOP;
    end else begin
      r = line_failed(r);
    end
    return r;
  endfunction

  function automatic txt_t line_end(txt_t s);
    txt_t r;
    r = s;
    if (r.line_phase == LN_BLANKS) r = line_failed(r);
    else if (r.line_phase == LN_WORD) r = judge_word(r);
    if (r.line_phase != LN_STOP) r.line_phase = LN_BETWEEN;
    return r;
  endfunction

  function automatic txt_t obj_byte(txt_t s, logic [7:0] b, logic [7:0] max_lines);
    txt_t r;
    r = s;
    if (r.line_phase == LN_STOP) return r;
    if (b == 8'h0D || b == 8'h0A) return line_end(r);
    if (r.line_phase == LN_BETWEEN) begin
      if (r.obj_hit || r.lines_seen >= max_lines) begin
        r.line_phase = LN_STOP;
        return r;
      end
      r.line_phase = LN_BLANKS;
    end
    if (r.line_phase == LN_BLANKS) begin
      if (b == 8'h20 || b == 8'h09) return r;
      if (b == 8'h23) return line_failed(r);
      r.line_phase = LN_WORD;
      r.line_word = '0;
      r.word_len = 3'd0;
    end
    if (r.line_phase == LN_WORD) begin
      if (is_ws(b) || b == 8'h2F || b == 8'h5C) begin
        r = judge_word(r);
      end else if (r.word_len < 3'd6) begin
        r.line_word = {r.line_word[39:0], lower(b)};
        r.word_len = r.word_len + 3'd1;
      end else begin
        r.word_len = 3'd7;
      end
    end
    return r;
  endfunction

  function automatic txt_t text_step(txt_t s, logic [7:0] b, logic in_win,
                                     logic [7:0] max_lines);
    txt_t r;
    logic [7:0] c;
    r = s;
    c = lower(b);
    if (r.lead == LP_SKIP && !is_ws(b)) begin
      r.lead = LP_FOUND;
      r.fmc = b;
      if (in_win) r.solid = (c == SOLID_TOK[0]) ? 3'd1 : SOLID_FAIL;
    end else if (r.lead == LP_FOUND && in_win && r.solid >= 3'd1 && r.solid < 3'd5) begin
      r.solid = (c == SOLID_TOK[r.solid]) ? r.solid + 3'd1 : SOLID_FAIL;
    end
    if (!in_win) return r;
    r.facet = facet_step(r.facet, c);
    r.endsolid = ends_step(r.endsolid, c);
    if (r.solid == 3'd5 && (r.facet == 4'd12 || r.endsolid == 4'd8)) r.stl_hit = 1'b1;
    r = obj_byte(r, b, max_lines);
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mfs_in_if.sv @@
// Byte stream channel of the model format sniffer.
// Depends on nothing.
`default_nettype none

interface mfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mfs_out_if.sv @@
// Result channel of the model format sniffer.
// Depends on nothing.
`default_nettype none

interface mfs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] format;
  logic [2:0] reason;
  modport source (output valid, format, reason, input ready);
  modport sink (input valid, format, reason, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mfs_core.sv @@
// Sniffer state registers and per-byte update, including the head replay
// and the end-of-stream decision. Depends on mfs_pkg.
`default_nettype none

module mfs_core
  import mfs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [15:0] sample_window,
  input  wire logic [7:0]  max_lines,
  output result_t          result
);

  count_t      count, count_next;
  logic [31:0] head, head_next;
  logic [31:0] tri_cnt, tri_next;
  logic [5:0]  resid, resid_next;
  txt_t        txt, s0, s1, s2, s3;
  logic [1:0]  rep_cnt;
  logic        normal;
  logic [15:0] win;
  logic        in_win;
  logic [38:0] exact_len;

  assign win = (sample_window < 16'd4) ? 16'd4 : sample_window;
  assign in_win = count < count_t'(win);

  always_comb begin
    head_next = head;
    tri_next = tri_cnt;
    if (count < count_t'(4)) head_next[8*count[1:0] +: 8] = data_byte;
    if (count >= count_t'(80) && count < count_t'(84))
      tri_next[8*count[1:0] +: 8] = data_byte;

    count_next = count;
    resid_next = resid;
    if (count != '1) begin
      count_next = count + count_t'(1);
      resid_next = (resid == 6'd49) ? 6'd0 : resid + 6'd1;
    end

    s0 = txt;
    rep_cnt = 2'd0;
    normal = 1'b0;
    if (txt.lead == LP_WAIT) begin
      if (count == count_t'(2)) begin
        s0.lead = LP_SKIP;
        if (head_next[23:0] != 24'hBFBBEF) rep_cnt = 2'd3;
      end
    end else begin
      normal = 1'b1;
    end
    // short stream ended before the BOM decision: replay what arrived
    if (last_byte && s0.lead == LP_WAIT) begin
      s0.lead = LP_SKIP;
      rep_cnt = count_next[1:0];
    end

    if (normal) s1 = text_step(s0, data_byte, in_win, max_lines);
    else if (rep_cnt > 2'd0) s1 = text_step(s0, head_next[7:0], 1'b1, max_lines);
    else s1 = s0;
    s2 = (rep_cnt > 2'd1) ? text_step(s1, head_next[15:8], 1'b1, max_lines) : s1;
    s3 = (rep_cnt > 2'd2) ? text_step(s2, head_next[23:16], 1'b1, max_lines) : s2;
    if (last_byte && s3.line_phase != LN_STOP) s3 = line_end(s3);

    exact_len = {tri_next, 5'b0} + {2'b0, tri_next, 4'b0} + {6'b0, tri_next, 1'b0}
              + 39'd84;

    result = '{format: FMT_GLB, reason: RSN_UNKNOWN};
    if (count_next >= count_t'(4) && head_next == 32'h46546C67)
      result = '{format: FMT_GLB, reason: RSN_GLTF};
    else if (count_next >= count_t'(4) && head_next == 32'h04034B50)
      result = '{format: FMT_3MF, reason: RSN_ZIP};
    else if (s3.lead == LP_FOUND && s3.fmc == 8'h7B)
      result = '{format: FMT_GLTF, reason: RSN_JSON};
    else if (s3.stl_hit)
      result = '{format: FMT_STL, reason: RSN_ASCII_STL};
    else if (count_next >= count_t'(84) && exact_len == 39'(count_next))
      result = '{format: FMT_STL, reason: RSN_STL_EXACT};
    else if (count_next >= count_t'(84) && resid_next == 6'd34)
      result = '{format: FMT_STL, reason: RSN_STL_STRD};
    else if (s3.obj_hit)
      result = '{format: FMT_OBJ, reason: RSN_OBJ};
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      count <= '0;
      head <= '0;
      tri_cnt <= '0;
      resid <= '0;
      txt <= '0;
    end else if (step) begin
      count <= count_next;
      head <= head_next;
      tri_cnt <= tri_next;
      resid <= resid_next;
      txt <= s3;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/model_format_sniffer.sv @@
// Model format sniffer top level: byte input register, sniffer core, result
// register and APB register port. Depends on mfs_pkg, mfs_in_if, mfs_out_if, mfs_core.
`default_nettype none

// Takes a model file as a stream of bytes, one per item, with last_byte set on
// the final byte, and returns one item per stream on the final byte: a format
// class and the reason that chose it. Priority: glTF magic, ZIP signature,
// '{' after an optional UTF-8 BOM and whitespace, ASCII STL, binary STL
// exact size, binary STL 50-byte stride, OBJ line token, else unknown.
// One byte is accepted every clock cycle unless a final byte is stalled; a byte
// passes an input register and the matcher logic into the result register, so
// the result is offered from that register once the final byte leaves the input
// register. The result register lets the next stream flow in while a result
// waits; a final byte stalls only while that register still holds an untaken
// result. Registers: sample_window at 0x0, max_lines at 0x4.
module model_format_sniffer
  import mfs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  mfs_in_if.sink           byte_ch,
  mfs_out_if.source        result_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] sample_window;
  logic [7:0]  max_lines;

  logic        iv;
  logic [7:0]  ib;
  logic        il;
  logic        fire;
  logic        ov;
  result_t     res, res_q;

  // register port: address bit 2 picks the register
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {24'b0, max_lines} : {16'b0, sample_window};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_window <= 16'd16384;
      max_lines <= 8'd64;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) max_lines <= pwdata[7:0];
      else sample_window <= pwdata[15:0];
    end
  end

  // advance the held byte unless it is a final byte and the result slot is blocked
  assign fire = iv && (!il || !ov || result_ch.ready);
  assign byte_ch.ready = !iv || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (byte_ch.valid && byte_ch.ready) begin
      iv <= 1'b1;
    end else if (fire) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      ib <= byte_ch.data_byte;
      il <= byte_ch.last_byte;
    end
  end

  mfs_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (fire),
    .data_byte     (ib),
    .last_byte     (il),
    .sample_window (sample_window),
    .max_lines     (max_lines),
    .result        (res)
  );

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (fire && il) begin
      ov <= 1'b1;
    end else if (result_ch.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && il) res_q <= res;
  end

  assign result_ch.valid = ov;
  assign result_ch.format = res_q.format;
  assign result_ch.reason = res_q.reason;

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire && il |=> ov)
    else $error("final byte gave no result");
  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !iv |-> byte_ch.ready)
    else $error("empty input register refused a byte");
  a_unknown_is_glb: assert property (@(posedge clk) disable iff (rst)
    ov && res_q.reason == RSN_UNKNOWN |-> res_q.format == FMT_GLB)
    else $error("unknown reason with non-default format");
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    ov && !result_ch.ready |-> !(fire && il))
    else $error("result overwritten before taken");
`endif

endmodule

`default_nettype wire
